// File: sv/tgr_pkg.sv
// ----------------------------------------------------------------------------
// Touch gesture recognizer package
// Shared types, command and event codes, register indexes and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

   localparam logic [2:0] CMD_DOWN   = 3'd0;
   localparam logic [2:0] CMD_MOVE   = 3'd1;
   localparam logic [2:0] CMD_UP     = 3'd2;
   localparam logic [2:0] CMD_CANCEL = 3'd3;
   localparam logic [2:0] CMD_SCROLL = 3'd4;
   localparam logic [2:0] CMD_TICK   = 3'd5;

   localparam logic [2:0] EV_HOVER_MOVE   = 3'd0;
   localparam logic [2:0] EV_POINTER_DOWN = 3'd1;
   localparam logic [2:0] EV_POINTER_UP   = 3'd2;
   localparam logic [2:0] EV_TAP          = 3'd3;
   localparam logic [2:0] EV_PAN_BEGIN    = 3'd4;
   localparam logic [2:0] EV_PAN_MOVE     = 3'd5;
   localparam logic [2:0] EV_LONG_PRESS   = 3'd6;
   localparam logic [2:0] EV_SCROLL       = 3'd7;

   localparam logic [1:0] CSR_PAN_THRESHOLD    = 2'd0;
   localparam logic [1:0] CSR_TAP_DISTANCE     = 2'd1;
   localparam logic [1:0] CSR_TAP_TIMEOUT      = 2'd2;
   localparam logic [1:0] CSR_LONG_PRESS_DELAY = 2'd3;

   localparam logic [11:0] PAN_THRESHOLD_RST    = 12'd160;
   localparam logic [11:0] TAP_DISTANCE_RST     = 12'd160;
   localparam logic [15:0] TAP_TIMEOUT_RST      = 16'd300;
   localparam logic [15:0] LONG_PRESS_DELAY_RST = 16'd500;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [3:0]         pointer_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [31:0]        time_ms;
      logic signed [15:0] wheel_x;
      logic signed [15:0] wheel_y;
   } req_type;

   typedef struct packed {
      logic [2:0]         event_kind;
      logic [3:0]         out_pointer;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic [31:0]        out_time;
      logic signed [15:0] out_wheel_x;
      logic signed [15:0] out_wheel_y;
      logic               last_event;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] press_x;
      logic signed [15:0] press_y;
      logic signed [15:0] latest_x;
      logic signed [15:0] latest_y;
      logic [31:0]        press_time;
   } slot_entry_type;

   typedef struct packed {
      logic [3:0]     pointer;
      slot_entry_type entry;
      logic           el_lt_tap;
      logic           el_ge_lp;
   } stage_type;

   function automatic rsp_type make_event(input logic [2:0] kind, input logic [3:0] ptr,
                                          input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic [31:0] t);
      rsp_type ev;
      ev             = '0;
      ev.event_kind  = kind;
      ev.out_pointer = ptr;
      ev.out_x       = x;
      ev.out_y       = y;
      ev.out_time    = t;
      return ev;
   endfunction

endpackage

`default_nettype wire

// File: sv/tgr_slot_mem.sv
// ----------------------------------------------------------------------------
// Slot memory
// Per-pointer press and latest positions and press time, one read and one
// write port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_slot_mem import tgr_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  slot_entry_type wr_data,
   input  logic [AW-1:0]  rd_addr,
   output slot_entry_type rd_data
);

   slot_entry_type slot_mem [DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/tgr_dist.sv
// ----------------------------------------------------------------------------
// Distance pipeline
// Three-stage squared distance with threshold compares: difference, square,
// then sum and compare against the squared thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_dist import tgr_pkg::*; (
   input  logic               clock,
   input  logic signed [15:0] cur_x,
   input  logic signed [15:0] cur_y,
   input  logic signed [15:0] ref_x,
   input  logic signed [15:0] ref_y,
   input  logic [11:0]        pan_threshold,
   input  logic [11:0]        tap_distance,
   output logic               gt_pan,
   output logic               lt_tap
);

   logic signed [16:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [31:0]        prod_x, prod_y;
   logic [31:0]        sqx_ff, sqy_ff;
   logic [32:0]        sum;
   logic [23:0]        pan_sq_ff, tap_sq_ff;
   logic               gt_pan_ff, lt_tap_ff;

   assign dx_in  = {cur_x[15], cur_x} - {ref_x[15], ref_x};
   assign dy_in  = {cur_y[15], cur_y} - {ref_y[15], ref_y};
   assign prod_x = 32'(dx_ff) * 32'(dx_ff);
   assign prod_y = 32'(dy_ff) * 32'(dy_ff);
   assign sum    = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      pan_sq_ff <= 24'(pan_threshold) * 24'(pan_threshold);
      tap_sq_ff <= 24'(tap_distance) * 24'(tap_distance);
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sqx_ff    <= prod_x;
      sqy_ff    <= prod_y;
      gt_pan_ff <= sum > {9'd0, pan_sq_ff};
      lt_tap_ff <= sum < {9'd0, tap_sq_ff};
   end

   assign gt_pan = gt_pan_ff;
   assign lt_tap = lt_tap_ff;

endmodule

`default_nettype wire

// File: sv/tgr_emit.sv
// ----------------------------------------------------------------------------
// Event emitter
// Holds one pending event so that the final event of a transaction can be
// marked, and drives the registered result strobe and payload.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_emit import tgr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    ev_a_vld,
   input  rsp_type ev_a,
   input  logic    ev_b_vld,
   input  rsp_type ev_b,
   input  logic    flush,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic    out_vld_ff, out_vld_in, pend_vld_ff, pend_vld_in;
   rsp_type out_ff, out_in, pend_ff, pend_in;

   always_comb begin
      out_vld_in  = 1'b0;
      out_in      = pend_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      if (ev_a_vld) begin
         pend_vld_in = 1'b1;
         if (pend_vld_ff) begin
            out_vld_in        = 1'b1;
            out_in.last_event = 1'b0;
            pend_in           = ev_a;
         end else if (ev_b_vld) begin
            out_vld_in        = 1'b1;
            out_in            = ev_a;
            out_in.last_event = 1'b0;
            pend_in           = ev_b;
         end else begin
            pend_in = ev_a;
         end
      end else if (flush && pend_vld_ff) begin
         out_vld_in        = 1'b1;
         out_in.last_event = 1'b1;
         pend_vld_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_pair_alone: assert property (@(posedge clock) disable iff (reset)
      ev_b_vld |-> (ev_a_vld && !pend_vld_ff))
      else $error("Second event arrived without a first or with one pending.");

   a_flush_quiet: assert property (@(posedge clock) disable iff (reset)
      flush |-> !ev_a_vld)
      else $error("Flush coincided with a new event.");

endmodule

`default_nettype wire

// File: sv/touch_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// Touch gesture recognizer
// Per-pointer tap, pan and long-press detection over a slot memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Busy stays high
// until the pipeline has drained. Down, move, up, cancel and scroll issue a
// single slot read; a tick reads the slot memory one slot per cycle, and each
// read then passes the difference, square and compare stages of the pipeline.
// Results follow on rsp_valid, with last_event set on the final result of the
// transaction. The result channel cannot be stalled. Configuration writes
// are always ready and are meant to be made while busy is low.
`default_nettype none

module touch_gesture_recognizer import tgr_pkg::*; #(
   parameter int MAX_POINTERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int SLOT_W = (MAX_POINTERS > 1) ? $clog2(MAX_POINTERS) : 1;

   logic [11:0] pan_threshold_ff, tap_distance_ff;
   logic [15:0] tap_timeout_ff, long_press_delay_ff;

   state_type   state_ff, state_in;
   req_type     req_ff;
   logic        ok_ff, in_ok, take, is_tick, issue_vld, flush, pipe_busy;
   logic [SLOT_W-1:0] cnt_ff, cnt_in, single_slot_ff, iss_slot;
   logic [3:0]        iss_ptr;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [SLOT_W-1:0] p1_slot_ff, p2_slot_ff, p3_slot_ff, p4_slot_ff;
   logic [3:0]        p1_ptr_ff;
   stage_type         p2_ff, p3_ff, p4_ff, p2_in;

   slot_entry_type rd_data, wr_data;
   logic           wr_en;
   logic [31:0]    elapsed;
   logic signed [15:0] cur_x, cur_y;
   logic           gt_pan, lt_tap;

   logic [MAX_POINTERS-1:0] present_ff, active_ff, armed_ff, pan_ff;
   logic [MAX_POINTERS-1:0] present_in, active_in, armed_in, pan_in;
   logic    pres4, begin_pan;
   logic    ev_a_vld, ev_b_vld;
   rsp_type ev_a, ev_b;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_threshold_ff    <= PAN_THRESHOLD_RST;
         tap_distance_ff     <= TAP_DISTANCE_RST;
         tap_timeout_ff      <= TAP_TIMEOUT_RST;
         long_press_delay_ff <= LONG_PRESS_DELAY_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PAN_THRESHOLD:    pan_threshold_ff    <= csr_data[11:0];
            CSR_TAP_DISTANCE:     tap_distance_ff     <= csr_data[11:0];
            CSR_TAP_TIMEOUT:      tap_timeout_ff      <= csr_data;
            CSR_LONG_PRESS_DELAY: long_press_delay_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer.
   assign busy      = (state_ff != ST_IDLE);
   assign take      = start && !busy;
   assign is_tick   = (req_ff.command == CMD_TICK);
   assign pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;
   assign in_ok     = int'(req_data.pointer_id) < MAX_POINTERS;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!is_tick || cnt_ff == SLOT_W'(MAX_POINTERS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      issue_vld = 1'b0;
      flush     = 1'b0;
      case (state_ff)
         ST_SCAN:  issue_vld = 1'b1;
         ST_DRAIN: flush     = !pipe_busy;
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (take) begin
         cnt_in = '0;
      end else if (issue_vld) begin
         cnt_in = cnt_ff + SLOT_W'(1);
      end
   end

   assign iss_slot = is_tick ? cnt_ff : single_slot_ff;
   assign iss_ptr  = is_tick ? 4'(cnt_ff) : req_ff.pointer_id;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         v1_ff    <= issue_vld;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff         <= req_data;
         ok_ff          <= in_ok || (req_data.command == CMD_TICK);
         single_slot_ff <= in_ok ? SLOT_W'(req_data.pointer_id) : '0;
      end
   end

   // Slot memory and the stages behind its read port.
   tgr_slot_mem #(
      .DEPTH (MAX_POINTERS),
      .AW    (SLOT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (p4_slot_ff),
      .wr_data (wr_data),
      .rd_addr (iss_slot),
      .rd_data (rd_data)
   );

   assign elapsed = req_ff.time_ms - rd_data.press_time;
   assign cur_x   = is_tick ? rd_data.latest_x : req_ff.pos_x;
   assign cur_y   = is_tick ? rd_data.latest_y : req_ff.pos_y;

   always_comb begin
      p2_in.pointer   = p1_ptr_ff;
      p2_in.entry     = rd_data;
      p2_in.el_lt_tap = elapsed < {16'd0, tap_timeout_ff};
      p2_in.el_ge_lp  = elapsed >= {16'd0, long_press_delay_ff};
   end

   always_ff @(posedge clock) begin
      p1_slot_ff <= iss_slot;
      p1_ptr_ff  <= iss_ptr;
      p2_slot_ff <= p1_slot_ff;
      p3_slot_ff <= p2_slot_ff;
      p4_slot_ff <= p3_slot_ff;
      p2_ff      <= p2_in;
      p3_ff      <= p2_ff;
      p4_ff      <= p3_ff;
   end

   tgr_dist u_dist (
      .clock         (clock),
      .cur_x         (cur_x),
      .cur_y         (cur_y),
      .ref_x         (rd_data.press_x),
      .ref_y         (rd_data.press_y),
      .pan_threshold (pan_threshold_ff),
      .tap_distance  (tap_distance_ff),
      .gt_pan        (gt_pan),
      .lt_tap        (lt_tap)
   );

   // Commit stage: flag updates, write-back and events.
   assign pres4     = present_ff[p4_slot_ff] && ok_ff;
   assign begin_pan = gt_pan && !pan_ff[p4_slot_ff];

   always_comb begin
      present_in = present_ff;
      active_in  = active_ff;
      armed_in   = armed_ff;
      pan_in     = pan_ff;
      wr_en      = 1'b0;
      wr_data    = p4_ff.entry;
      ev_a_vld   = 1'b0;
      ev_b_vld   = 1'b0;
      ev_a       = make_event(EV_POINTER_UP, p4_ff.pointer, req_ff.pos_x, req_ff.pos_y,
                              req_ff.time_ms);
      ev_b       = ev_a;
      if (v4_ff) begin
         case (req_ff.command)
            CMD_DOWN: begin
               ev_a_vld = 1'b1;
               ev_a.event_kind = EV_POINTER_DOWN;
               if (ok_ff) begin
                  present_in[p4_slot_ff] = 1'b1;
                  active_in[p4_slot_ff]  = 1'b1;
                  armed_in[p4_slot_ff]   = 1'b1;
                  wr_en                  = 1'b1;
                  wr_data.press_x        = req_ff.pos_x;
                  wr_data.press_y        = req_ff.pos_y;
                  wr_data.latest_x       = req_ff.pos_x;
                  wr_data.latest_y       = req_ff.pos_y;
                  wr_data.press_time     = req_ff.time_ms;
               end
            end
            CMD_MOVE: begin
               if (!pres4 || !active_ff[p4_slot_ff]) begin
                  ev_a_vld = 1'b1;
                  ev_a.event_kind = EV_HOVER_MOVE;
               end else if (begin_pan) begin
                  pan_in[p4_slot_ff] = 1'b1;
                  ev_a_vld = 1'b1;
                  ev_a = make_event(EV_PAN_BEGIN, p4_ff.pointer, p4_ff.entry.press_x,
                                    p4_ff.entry.press_y, req_ff.time_ms);
                  ev_b_vld = 1'b1;
                  ev_b.event_kind = EV_PAN_MOVE;
               end else if (pan_ff[p4_slot_ff]) begin
                  ev_a_vld = 1'b1;
                  ev_a.event_kind = EV_PAN_MOVE;
               end
               if (pres4) begin
                  wr_en            = 1'b1;
                  wr_data.latest_x = req_ff.pos_x;
                  wr_data.latest_y = req_ff.pos_y;
               end
            end
            CMD_UP: begin
               if (pres4) begin
                  ev_a_vld = 1'b1;
                  if (p4_ff.el_lt_tap && lt_tap) begin
                     ev_a.event_kind = EV_TAP;
                     ev_b_vld = 1'b1;
                  end
                  present_in[p4_slot_ff] = 1'b0;
                  active_in[p4_slot_ff]  = 1'b0;
                  armed_in[p4_slot_ff]   = 1'b0;
               end
               if (ok_ff) begin
                  pan_in[p4_slot_ff] = 1'b0;
               end
            end
            CMD_CANCEL: begin
               if (pres4) begin
                  active_in[p4_slot_ff] = 1'b0;
               end
            end
            CMD_SCROLL: begin
               ev_a_vld = 1'b1;
               ev_a.event_kind  = EV_SCROLL;
               ev_a.out_wheel_x = req_ff.wheel_x;
               ev_a.out_wheel_y = req_ff.wheel_y;
            end
            CMD_TICK: begin
               if (present_ff[p4_slot_ff] && active_ff[p4_slot_ff] &&
                   armed_ff[p4_slot_ff] && lt_tap && p4_ff.el_ge_lp) begin
                  ev_a_vld = 1'b1;
                  ev_a = make_event(EV_LONG_PRESS, p4_ff.pointer, p4_ff.entry.press_x,
                                    p4_ff.entry.press_y, req_ff.time_ms);
                  armed_in[p4_slot_ff] = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         active_ff  <= '0;
         armed_ff   <= '0;
         pan_ff     <= '0;
      end else begin
         present_ff <= present_in;
         active_ff  <= active_in;
         armed_ff   <= armed_in;
         pan_ff     <= pan_in;
      end
   end

   tgr_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .ev_a_vld  (ev_a_vld),
      .ev_a      (ev_a),
      .ev_b_vld  (ev_b_vld),
      .ev_b      (ev_b),
      .flush     (flush),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pipe_busy)
      else $error("Pipeline holds work while the sequencer is idle.");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      take |=> busy)
      else $error("Accepted transaction did not raise busy.");

   a_flags_held: assert property (@(posedge clock) disable iff (reset)
      ((active_ff & ~present_ff) == '0) && ((armed_ff & ~present_ff) == '0))
      else $error("Active or armed flag set on an absent slot.");

endmodule

`default_nettype wire

// File: sim/touch_gesture_checker.sv
// ----------------------------------------------------------------------------
// Touch gesture checker
// Watches the request, result and register channels of the touch gesture
// recognizer. It keeps its own copy of the pointer table and of the
// registers, works out the events of every accepted transaction, and compares
// each result against the oldest pending event.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_checker import tgr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          mismatches,
   output int          outstanding,
   output int          compared
);

   localparam int SLOTS = 16;

   logic [11:0]        pan_thr;
   logic [11:0]        tap_dist;
   logic [15:0]        tap_tmo;
   logic [15:0]        hold_delay;

   logic [SLOTS-1:0]   present;
   logic [SLOTS-1:0]   active;
   logic [SLOTS-1:0]   armed;
   logic [SLOTS-1:0]   panning;
   logic signed [15:0] down_x [SLOTS];
   logic signed [15:0] down_y [SLOTS];
   logic signed [15:0] cur_x [SLOTS];
   logic signed [15:0] cur_y [SLOTS];
   logic [31:0]        down_t [SLOTS];

   rsp_type            pending_events [$];
   int                 error_count;
   int                 match_count;

   function automatic longint sq_dist(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                      input logic signed [15:0] bx, input logic signed [15:0] by);
      longint dx;
      longint dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return dx * dx + dy * dy;
   endfunction

   function automatic rsp_type gesture_event(input logic [2:0] kind, input logic [3:0] ptr,
                                             input logic signed [15:0] x,
                                             input logic signed [15:0] y,
                                             input logic [31:0] t,
                                             input logic signed [15:0] wx,
                                             input logic signed [15:0] wy);
      rsp_type ev;
      ev.event_kind  = kind;
      ev.out_pointer = ptr;
      ev.out_x       = x;
      ev.out_y       = y;
      ev.out_time    = t;
      ev.out_wheel_x = wx;
      ev.out_wheel_y = wy;
      ev.last_event  = 1'b0;
      return ev;
   endfunction

   function automatic string describe(input rsp_type e);
      return $sformatf("kind=%0d ptr=%0d x=%0d y=%0d t=%h wx=%0d wy=%0d last=%0d",
                       e.event_kind, e.out_pointer, e.out_x, e.out_y, e.out_time,
                       e.out_wheel_x, e.out_wheel_y, e.last_event);
   endfunction

   task automatic predict_gestures(input req_type r);
      rsp_type     batch [$];
      logic [3:0]  id;
      logic [31:0] elapsed;
      longint      tap_sq;
      id = r.pointer_id;
      tap_sq = longint'(tap_dist) * longint'(tap_dist);
      case (r.command)
         CMD_DOWN: begin
            present[id] = 1'b1;
            active[id]  = 1'b1;
            armed[id]   = 1'b1;
            down_x[id]  = r.pos_x;
            down_y[id]  = r.pos_y;
            cur_x[id]   = r.pos_x;
            cur_y[id]   = r.pos_y;
            down_t[id]  = r.time_ms;
            batch.insert(batch.size(), gesture_event(EV_POINTER_DOWN, id, r.pos_x, r.pos_y,
                                                     r.time_ms, '0, '0));
         end
         CMD_MOVE: begin
            if (!present[id] || !active[id]) begin
               batch.insert(batch.size(), gesture_event(EV_HOVER_MOVE, id, r.pos_x,
                                                        r.pos_y, r.time_ms, '0, '0));
            end else begin
               if (sq_dist(r.pos_x, r.pos_y, down_x[id], down_y[id]) >
                   longint'(pan_thr) * longint'(pan_thr) && !panning[id]) begin
                  panning[id] = 1'b1;
                  batch.insert(batch.size(), gesture_event(EV_PAN_BEGIN, id, down_x[id],
                                                           down_y[id], r.time_ms, '0, '0));
               end
               if (panning[id]) begin
                  batch.insert(batch.size(), gesture_event(EV_PAN_MOVE, id, r.pos_x,
                                                           r.pos_y, r.time_ms, '0, '0));
               end
            end
            if (present[id]) begin
               cur_x[id] = r.pos_x;
               cur_y[id] = r.pos_y;
            end
         end
         CMD_UP: begin
            if (present[id]) begin
               elapsed = r.time_ms - down_t[id];
               if (elapsed < {16'd0, tap_tmo} &&
                   sq_dist(r.pos_x, r.pos_y, down_x[id], down_y[id]) < tap_sq) begin
                  batch.insert(batch.size(), gesture_event(EV_TAP, id, r.pos_x, r.pos_y,
                                                           r.time_ms, '0, '0));
               end
               batch.insert(batch.size(), gesture_event(EV_POINTER_UP, id, r.pos_x,
                                                        r.pos_y, r.time_ms, '0, '0));
               present[id] = 1'b0;
               active[id]  = 1'b0;
               armed[id]   = 1'b0;
            end
            panning[id] = 1'b0;
         end
         CMD_CANCEL: begin
            if (present[id]) begin
               active[id] = 1'b0;
            end
         end
         CMD_SCROLL: begin
            batch.insert(batch.size(), gesture_event(EV_SCROLL, id, r.pos_x, r.pos_y,
                                                     r.time_ms, r.wheel_x, r.wheel_y));
         end
         CMD_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               elapsed = r.time_ms - down_t[i];
               if (present[i] && active[i] && armed[i] &&
                   sq_dist(cur_x[i], cur_y[i], down_x[i], down_y[i]) < tap_sq &&
                   elapsed >= {16'd0, hold_delay}) begin
                  batch.insert(batch.size(), gesture_event(EV_LONG_PRESS, 4'(i), down_x[i],
                                                           down_y[i], r.time_ms, '0, '0));
                  armed[i] = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      if (batch.size() > 0) begin
         batch[batch.size() - 1].last_event = 1'b1;
      end
      foreach (batch[k]) begin
         pending_events.insert(pending_events.size(), batch[k]);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pan_thr    = PAN_THRESHOLD_RST;
         tap_dist   = TAP_DISTANCE_RST;
         tap_tmo    = TAP_TIMEOUT_RST;
         hold_delay = LONG_PRESS_DELAY_RST;
         present    = '0;
         active     = '0;
         armed      = '0;
         panning    = '0;
         pending_events.delete();
         error_count = 0;
         match_count = 0;
      end else begin
         if (rsp_valid) begin
            if (pending_events.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("ERROR %0t: unexpected event %s", $realtime, describe(rsp_data));
               end
            end else begin
               want = pending_events.pop_front();
               match_count++;
               if (rsp_data !== want) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("ERROR %0t: event mismatch", $realtime);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(rsp_data));
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PAN_THRESHOLD:    pan_thr    = csr_data[11:0];
               CSR_TAP_DISTANCE:     tap_dist   = csr_data[11:0];
               CSR_TAP_TIMEOUT:      tap_tmo    = csr_data;
               CSR_LONG_PRESS_DELAY: hold_delay = csr_data;
               default: begin
               end
            endcase
         end
         if (start && !busy) begin
            predict_gestures(req_data);
         end
      end
      mismatches  <= error_count;
      outstanding <= pending_events.size();
      compared    <= match_count;
   end

endmodule

`default_nettype wire

// File: sim/tb_touch_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// Touch gesture recognizer testbench
// Drives directed pointer sequences and then random gesture streams through
// several register settings, with random gaps between transactions. The
// checker beside the block predicts and compares every event.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_touch_gesture_recognizer;
   import tgr_pkg::*;

   localparam logic [2:0] CMD_SPARE_A        = 3'd6;
   localparam logic [2:0] CMD_SPARE_B        = 3'd7;
   localparam int         SETTLE_CYCLES      = 24;
   localparam int         DRAIN_LIMIT        = 4000;
   localparam int         RANDOM_PER_SETTING = 25;
   localparam int         SETTING_COUNT      = 5;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [15:0]        csr_data;

   int                 mismatches;
   int                 outstanding;
   int                 compared;
   int                 commands_sent;
   int                 settings_used;
   bit                 quiet_tail;
   logic [31:0]        now;
   logic signed [15:0] home_x [16];
   logic signed [15:0] home_y [16];

   touch_gesture_recognizer dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   touch_gesture_checker gesture_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .compared    (compared)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic req_type gesture_item(input logic [2:0] cmd, input logic [3:0] id,
                                            input logic signed [15:0] x,
                                            input logic signed [15:0] y,
                                            input logic [31:0] t);
      req_type r;
      r.command    = cmd;
      r.pointer_id = id;
      r.pos_x      = x;
      r.pos_y      = y;
      r.time_ms    = t;
      r.wheel_x    = 16'($urandom);
      r.wheel_y    = 16'($urandom);
      return r;
   endfunction

   task automatic send_item(input req_type r);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      commands_sent++;
   endtask

   task automatic drain_block();
      int guard;
      guard = 0;
      start <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while ((outstanding != 0 || busy) && guard < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(input logic [11:0] pan, input logic [11:0] tap,
                                 input logic [15:0] tmo, input logic [15:0] hold);
      write_reg(CSR_PAN_THRESHOLD, {4'($urandom), pan});
      write_reg(CSR_TAP_DISTANCE, {4'($urandom), tap});
      write_reg(CSR_TAP_TIMEOUT, tmo);
      write_reg(CSR_LONG_PRESS_DELAY, hold);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_gesture();
      int                 pick;
      int                 reach;
      logic [3:0]         id;
      logic signed [15:0] x;
      logic signed [15:0] y;
      req_type            r;
      pick = $urandom_range(0, 99);
      id = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      now += $urandom_range(0, 120);
      if ($urandom_range(0, 15) == 0) begin
         now += $urandom_range(0, 70000);
      end
      reach = ($urandom_range(0, 3) == 0) ? 4000 : 150;
      x = home_x[id] + 16'($urandom_range(0, 2 * reach)) - 16'(reach);
      y = home_y[id] + 16'($urandom_range(0, 2 * reach)) - 16'(reach);
      if (pick < 20) begin
         x = 16'($urandom);
         y = 16'($urandom);
         home_x[id] = x;
         home_y[id] = y;
         r = gesture_item(CMD_DOWN, id, x, y, now);
      end else if (pick < 50) begin
         r = gesture_item(CMD_MOVE, id, x, y, now);
      end else if (pick < 65) begin
         r = gesture_item(CMD_UP, id, x, y, now);
      end else if (pick < 72) begin
         r = gesture_item(CMD_CANCEL, id, x, y, now);
      end else if (pick < 78) begin
         r = gesture_item(CMD_SCROLL, id, 16'($urandom), 16'($urandom), now);
      end else if (pick < 90) begin
         r = gesture_item(CMD_TICK, id, x, y, now);
      end else begin
         r = gesture_item(3'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                          $urandom);
      end
      send_item(r);
   endtask

   initial begin
      req_type r;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_PAN_THRESHOLD;
      csr_data  <= '0;
      commands_sent = 0;
      settings_used = 1;
      quiet_tail    = 1'b0;
      foreach (home_x[i]) begin
         home_x[i] = '0;
         home_y[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_item(gesture_item(CMD_DOWN, 4'd0, 16'sh8000, 16'sh7FFF, 32'd1000));
      send_item(gesture_item(CMD_MOVE, 4'd0, 16'sh8064, 16'sh7FFF, 32'd1010));
      send_item(gesture_item(CMD_MOVE, 4'd0, 16'sh80C8, 16'sh7FCD, 32'd1020));
      send_item(gesture_item(CMD_MOVE, 4'd0, 16'sh8000, 16'sh7FFF, 32'd1030));
      send_item(gesture_item(CMD_UP, 4'd0, 16'sh8000, 16'sh7FFF, 32'd1040));
      send_item(gesture_item(CMD_DOWN, 4'd1, 16'sh7FFF, 16'sh8000, 32'd2000));
      send_item(gesture_item(CMD_UP, 4'd1, 16'sh7FFF, 16'sh8000, 32'd2400));
      send_item(gesture_item(CMD_DOWN, 4'd2, 16'sd100, 16'sd100, 32'd3000));
      send_item(gesture_item(CMD_MOVE, 4'd2, 16'sd1000, 16'sd100, 32'd3010));
      send_item(gesture_item(CMD_DOWN, 4'd2, 16'sd200, 16'sd200, 32'd3020));
      send_item(gesture_item(CMD_MOVE, 4'd2, 16'sd200, 16'sd200, 32'd3030));
      send_item(gesture_item(CMD_DOWN, 4'd3, 16'sd5, 16'sd5, 32'd3100));
      send_item(gesture_item(CMD_CANCEL, 4'd3, 16'sd5, 16'sd5, 32'd3110));
      send_item(gesture_item(CMD_MOVE, 4'd3, 16'sd7, 16'sd7, 32'd3120));
      send_item(gesture_item(CMD_UP, 4'd3, 16'sd7, 16'sd7, 32'd3150));
      send_item(gesture_item(CMD_UP, 4'd4, 16'sd0, 16'sd0, 32'd3200));
      send_item(gesture_item(CMD_MOVE, 4'd4, -16'sd1, -16'sd1, 32'd3210));
      r = gesture_item(CMD_SCROLL, 4'd15, -16'sd1, -16'sd1, 32'd3300);
      r.wheel_x = 16'sh8000;
      r.wheel_y = 16'sh7FFF;
      send_item(r);
      r = gesture_item(CMD_SCROLL, 4'd5, 16'sd0, 16'sd0, 32'hFFFF_FFFF);
      r.wheel_x = 16'sh7FFF;
      r.wheel_y = 16'sh8000;
      send_item(r);
      send_item(gesture_item(CMD_DOWN, 4'd15, 16'sd0, 16'sd0, 32'd4000));
      send_item(gesture_item(CMD_DOWN, 4'd6, -16'sd16, 16'sd16, 32'd4100));
      send_item(gesture_item(CMD_TICK, 4'd0, 16'sd0, 16'sd0, 32'd4550));
      send_item(gesture_item(CMD_TICK, 4'd9, 16'sd0, 16'sd0, 32'd4600));
      send_item(gesture_item(CMD_SPARE_A, 4'd6, 16'sd0, 16'sd0, 32'd4700));
      send_item(gesture_item(CMD_SPARE_B, 4'd15, 16'sd0, 16'sd0, 32'd4710));
      send_item(gesture_item(CMD_DOWN, 4'd7, 16'sd32, 16'sd32, 32'hFFFF_FFF0));
      send_item(gesture_item(CMD_UP, 4'd7, 16'sd32, 16'sd32, 32'h0000_0010));
      drain_block();

      now = $urandom;
      for (int phase = 0; phase < SETTING_COUNT; phase++) begin
         case (phase)
            1: apply_settings(12'd0, 12'd0, 16'd0, 16'd0);
            2: apply_settings(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
            3: apply_settings(12'($urandom_range(0, 400)), 12'($urandom_range(0, 400)),
                              16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)));
            4: apply_settings(12'($urandom_range(50, 300)), 12'($urandom_range(50, 300)),
                              16'($urandom_range(100, 1000)), 16'($urandom_range(100, 1000)));
            default: begin
            end
         endcase
         quiet_tail = (phase == SETTING_COUNT - 1);
         repeat (RANDOM_PER_SETTING) random_gesture();
         drain_block();
      end

      $display("Sent %0d commands under %0d register settings; %0d events compared.",
               commands_sent, settings_used, compared);
      $display("Directed pan, tap, long-press, cancel and time-wrap cases ran first.");
      if (outstanding != 0) begin
         $display("ERROR: %0d expected events never arrived", outstanding);
      end
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("ERROR: run did not finish in time");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
sv/tgr_pkg.sv
sv/tgr_slot_mem.sv
sv/tgr_dist.sv
sv/tgr_emit.sv
sv/touch_gesture_recognizer.sv
sim/touch_gesture_checker.sv
sim/tb_touch_gesture_recognizer.sv
